[rtl/ted_pkg.sv]
`timescale 1ns / 1ps

package ted_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned EncW    = 3;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 8;

  localparam logic [DataW-1:0] BOM8_B0   = 8'hEF;
  localparam logic [DataW-1:0] BOM8_B1   = 8'hBB;
  localparam logic [DataW-1:0] BOM8_B2   = 8'hBF;
  localparam logic [DataW-1:0] BOM16_FF  = 8'hFF;
  localparam logic [DataW-1:0] BOM16_FE  = 8'hFE;
  localparam logic [DataW-1:0] LEAD2_PAT = 8'hC0;
  localparam logic [DataW-1:0] LEAD2_MSK = 8'hE0;
  localparam logic [DataW-1:0] LEAD3_PAT = 8'hE0;
  localparam logic [DataW-1:0] LEAD3_MSK = 8'hF0;
  localparam logic [DataW-1:0] LEAD4_PAT = 8'hF0;
  localparam logic [DataW-1:0] LEAD4_MSK = 8'hF8;
  localparam logic [DataW-1:0] CONT_PAT  = 8'h80;
  localparam logic [DataW-1:0] CONT_MSK  = 8'hC0;

  typedef enum logic [EncW-1:0] {
    KIND_ANSI     = 3'd0,
    KIND_UTF8     = 3'd1,
    KIND_UTF8_BOM = 3'd2,
    KIND_UTF16LE  = 3'd3,
    KIND_UTF16BE  = 3'd4
  } enc_t;

  typedef struct packed {
    logic [1:0]       bytes_seen;
    logic [DataW-1:0] first_byte;
    logic [DataW-1:0] second_byte;
    logic             utf8_mark_seen;
    logic [1:0]       continuations_due;
    logic             not_utf8;
  } ted_state_t;

  typedef struct packed {
    enc_t encoding;
    logic has_bom;
  } ted_verdict_t;

endpackage

[rtl/ted_step.sv]
`timescale 1ns / 1ps

module ted_step (
  input  ted_pkg::ted_state_t       state_i,
  input  logic [ted_pkg::DataW-1:0] data_byte,
  output ted_pkg::ted_state_t       state_o,
  output ted_pkg::ted_verdict_t     verdict_o
);

  ted_pkg::ted_state_t s;
  logic is_cont;

  always_comb begin
    s = state_i;
    is_cont = ((data_byte & ted_pkg::CONT_MSK) == ted_pkg::CONT_PAT);

    // capture the leading bytes for mark detection
    unique case (state_i.bytes_seen)
      2'd0: s.first_byte = data_byte;
      2'd1: s.second_byte = data_byte;
      2'd2: begin
        if (state_i.first_byte == ted_pkg::BOM8_B0 && state_i.second_byte == ted_pkg::BOM8_B1 &&
            data_byte == ted_pkg::BOM8_B2) begin
          s.utf8_mark_seen = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_i.bytes_seen != 2'd3) begin
      s.bytes_seen = state_i.bytes_seen + 2'd1;
    end

    // lax utf-8 continuation check
    if (!state_i.not_utf8) begin
      if (state_i.continuations_due != 2'd0) begin
        if (!is_cont) begin
          s.not_utf8 = 1'b1;
          s.continuations_due = 2'd0;
        end else begin
          s.continuations_due = state_i.continuations_due - 2'd1;
        end
      end else begin
        priority if (!data_byte[ted_pkg::DataW-1]) begin
          s.continuations_due = 2'd0;
        end else if ((data_byte & ted_pkg::LEAD2_MSK) == ted_pkg::LEAD2_PAT) begin
          s.continuations_due = 2'd1;
        end else if ((data_byte & ted_pkg::LEAD3_MSK) == ted_pkg::LEAD3_PAT) begin
          s.continuations_due = 2'd2;
        end else if ((data_byte & ted_pkg::LEAD4_MSK) == ted_pkg::LEAD4_PAT) begin
          s.continuations_due = 2'd3;
        end else begin
          s.not_utf8 = 1'b1;
        end
      end
    end

    state_o = s;

    verdict_o.has_bom = 1'b1;
    priority if (s.utf8_mark_seen) begin
      verdict_o.encoding = ted_pkg::KIND_UTF8_BOM;
    end else if (s.bytes_seen >= 2'd2 && s.first_byte == ted_pkg::BOM16_FF &&
                 s.second_byte == ted_pkg::BOM16_FE) begin
      verdict_o.encoding = ted_pkg::KIND_UTF16LE;
    end else if (s.bytes_seen >= 2'd2 && s.first_byte == ted_pkg::BOM16_FE &&
                 s.second_byte == ted_pkg::BOM16_FF) begin
      verdict_o.encoding = ted_pkg::KIND_UTF16BE;
    end else begin
      verdict_o.has_bom = 1'b0;
      verdict_o.encoding = (s.not_utf8 || s.continuations_due != 2'd0) ?
                           ted_pkg::KIND_ANSI : ted_pkg::KIND_UTF8;
    end
  end

endmodule

[rtl/text_encoding_detector.sv]
`timescale 1ns / 1ps

// Classifies a byte stream as ANSI, UTF-8, UTF-8 with BOM, UTF-16 LE or UTF-16 BE. One byte
// is taken per beat on in_tdata, with in_tlast on the final byte of the stream; a stream
// holds at least one byte. Exactly one verdict beat leaves for each stream, after its last
// byte, carrying the encoding code in out_tdata and the byte order mark flag in out_tuser,
// and all stream state clears so the next byte opens a new stream. Bytes are accepted at one
// per cycle: an input register feeds a single stage of shallow classification logic into the
// verdict register, and a byte waits only while a finished verdict is held by out_tready.

module text_encoding_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ted_pkg::InTdataW-1:0]      in_tdata,   // data_byte[7:0]
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ted_pkg::OutTdataW-1:0]     out_tdata,  // encoding[2:0], zero fill
  output logic                              out_tuser   // has_bom
);

  logic                      s1_valid_r;
  logic [ted_pkg::DataW-1:0] s1_data_r;
  logic                      s1_last_r;
  logic                      s1_adv;

  ted_pkg::ted_state_t   state_r;
  ted_pkg::ted_state_t   state_nxt;
  ted_pkg::ted_verdict_t verdict;

  logic                  out_valid_r;
  ted_pkg::ted_verdict_t out_verdict_r;

  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  ted_step u_step (
    .state_i   (state_r),
    .data_byte (s1_data_r),
    .state_o   (state_nxt),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[ted_pkg::DataW-1:0];
      s1_last_r <= in_tlast;
    end
  end

  // stream state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= s1_last_r ? '0 : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ted_pkg::OutTdataW-ted_pkg::EncW){1'b0}}, out_verdict_r.encoding};
  assign out_tuser  = out_verdict_r.has_bom;

endmodule

[test/text_encoding_detector_tb.sv]
`timescale 1ns / 1ps

module text_encoding_detector_tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomBytes   = 1150;
  localparam int unsigned DirRowCount   = 24;

  typedef struct packed {
    ted_pkg::enc_t encoding;
    logic          has_bom;
  } verdict_t;

  typedef struct packed {
    logic [ted_pkg::DataW-1:0] data;
    logic                      last;
    logic                      fixed_exp;
    ted_pkg::enc_t             encoding;
    logic                      has_bom;
  } dir_row_t;

  // short streams: extremes, every verdict, every way to fail utf-8
  localparam dir_row_t DirRows [DirRowCount] = '{
    '{8'h00, 1'b1, 1'b1, ted_pkg::KIND_UTF8,     1'b0},
    '{8'hFF, 1'b1, 1'b1, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h80, 1'b1, 1'b1, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hEF, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hBB, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hBF, 1'b1, 1'b1, ted_pkg::KIND_UTF8_BOM, 1'b1},
    '{8'hFF, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hFE, 1'b1, 1'b1, ted_pkg::KIND_UTF16LE,  1'b1},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hFF, 1'b1, 1'b1, ted_pkg::KIND_UTF16BE,  1'b1},
    '{8'hC3, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hA9, 1'b1, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hE2, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h82, 1'b1, 1'b1, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hF0, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h9F, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h98, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h80, 1'b1, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hC3, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h41, 1'b1, 1'b1, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hFF, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h00, 1'b0, 1'b0, ted_pkg::KIND_ANSI,     1'b0},
    '{8'h80, 1'b1, 1'b1, ted_pkg::KIND_UTF16LE,  1'b1}
  };

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [ted_pkg::InTdataW-1:0]  in_tdata   = '0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [ted_pkg::OutTdataW-1:0] out_tdata;
  logic                          out_tuser;

  // stream state of the predictor
  logic [1:0]                seen_cnt;
  logic [ted_pkg::DataW-1:0] lead0;
  logic [ted_pkg::DataW-1:0] lead1;
  logic                      bom8_hit;
  logic [1:0]                cont_left;
  logic                      utf8_broken;

  verdict_t                  verdict_q [$];
  logic [ted_pkg::DataW-1:0] text_q [$];

  int unsigned fail_cnt    = 0;
  int unsigned sent_cnt    = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_tick     = 0;
  int unsigned rx_mode     = 0;

  text_encoding_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_stream();
    seen_cnt    = 2'd0;
    lead0       = '0;
    lead1       = '0;
    bom8_hit    = 1'b0;
    cont_left   = 2'd0;
    utf8_broken = 1'b0;
  endfunction

  function automatic bit judge_byte(input logic [ted_pkg::DataW-1:0] b, input logic last,
                                    output verdict_t v);
    v = '{ted_pkg::KIND_ANSI, 1'b0};
    case (seen_cnt)
      2'd0: lead0 = b;
      2'd1: lead1 = b;
      2'd2: begin
        if (lead0 == ted_pkg::BOM8_B0 && lead1 == ted_pkg::BOM8_B1 &&
            b == ted_pkg::BOM8_B2) bom8_hit = 1'b1;
      end
      default: ;
    endcase
    if (seen_cnt != 2'd3) seen_cnt = seen_cnt + 2'd1;

    if (!utf8_broken) begin
      if (cont_left != 2'd0) begin
        if ((b & ted_pkg::CONT_MSK) != ted_pkg::CONT_PAT) begin
          utf8_broken = 1'b1;
          cont_left   = 2'd0;
        end else begin
          cont_left = cont_left - 2'd1;
        end
      end else if (b[7]) begin
        if ((b & ted_pkg::LEAD2_MSK) == ted_pkg::LEAD2_PAT) cont_left = 2'd1;
        else if ((b & ted_pkg::LEAD3_MSK) == ted_pkg::LEAD3_PAT) cont_left = 2'd2;
        else if ((b & ted_pkg::LEAD4_MSK) == ted_pkg::LEAD4_PAT) cont_left = 2'd3;
        else utf8_broken = 1'b1;
      end
    end

    if (!last) return 1'b0;

    if (bom8_hit) begin
      v = '{ted_pkg::KIND_UTF8_BOM, 1'b1};
    end else if (seen_cnt >= 2'd2 && lead0 == ted_pkg::BOM16_FF &&
                 lead1 == ted_pkg::BOM16_FE) begin
      v = '{ted_pkg::KIND_UTF16LE, 1'b1};
    end else if (seen_cnt >= 2'd2 && lead0 == ted_pkg::BOM16_FE &&
                 lead1 == ted_pkg::BOM16_FF) begin
      v = '{ted_pkg::KIND_UTF16BE, 1'b1};
    end else begin
      v.encoding = (utf8_broken || cont_left != 2'd0) ? ted_pkg::KIND_ANSI
                                                      : ted_pkg::KIND_UTF8;
      v.has_bom  = 1'b0;
    end
    clear_stream();
    return 1'b1;
  endfunction

  function automatic void push_conts(input int unsigned n);
    repeat (n) text_q.push_back(ted_pkg::CONT_PAT | 8'($urandom_range(0, 63)));
  endfunction

  function automatic void push_char();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      text_q.push_back(8'($urandom_range(0, 127)));
    end else if (k < 65) begin
      text_q.push_back(ted_pkg::LEAD2_PAT | 8'($urandom_range(0, 31)));
      push_conts(1);
    end else if (k < 85) begin
      text_q.push_back(ted_pkg::LEAD3_PAT | 8'($urandom_range(0, 15)));
      push_conts(2);
    end else begin
      text_q.push_back(ted_pkg::LEAD4_PAT | 8'($urandom_range(0, 7)));
      push_conts(3);
    end
  endfunction

  task automatic send_beat(input logic [ted_pkg::DataW-1:0] b, input logic last,
                           input logic use_row, input verdict_t row_v);
    verdict_t v;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_cnt++;
    if (judge_byte(b, last, v)) verdict_q.push_back(use_row ? row_v : v);
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_tick % 5 != 0);
    endcase
  end

  always @(posedge clk) begin : verdict_check
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected verdict beat, expected none, actual encoding %0d has_bom %b",
                 $time, out_tdata, out_tuser);
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_tdata != {{(ted_pkg::OutTdataW-ted_pkg::EncW){1'b0}}, exp_v.encoding}) begin
          fail_cnt++;
          $display("%0t: encoding mismatch, expected %0d, actual %0d",
                   $time, exp_v.encoding, out_tdata);
        end
        if (out_tuser != exp_v.has_bom) begin
          fail_cnt++;
          $display("%0t: has_bom mismatch, expected %b, actual %b",
                   $time, exp_v.has_bom, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    verdict_t    row_v;
    int unsigned flavor;
    int unsigned flaw;

    clear_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DirRowCount; r++) begin
      row_v.encoding = DirRows[r].encoding;
      row_v.has_bom  = DirRows[r].has_bom;
      send_beat(DirRows[r].data, DirRows[r].last, DirRows[r].fixed_exp, row_v);
    end

    while (sent_cnt < DirRowCount + RandomBytes) begin
      text_q.delete();
      flavor = $urandom_range(0, 19);
      if (flavor < 10) begin
        // clean utf-8 text
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6))
          push_char();
      end else if (flavor < 13) begin
        // byte order marks and near misses
        case ($urandom_range(0, 6))
          0:       text_q = '{ted_pkg::BOM8_B0, ted_pkg::BOM8_B1, ted_pkg::BOM8_B2};
          1:       text_q = '{ted_pkg::BOM16_FF, ted_pkg::BOM16_FE};
          2:       text_q = '{ted_pkg::BOM16_FE, ted_pkg::BOM16_FF};
          3:       text_q = '{ted_pkg::BOM8_B0, ted_pkg::BOM8_B1};
          4:       text_q = '{ted_pkg::BOM8_B0, ted_pkg::BOM8_B1, 8'($urandom_range(0, 255))};
          5:       text_q = '{ted_pkg::BOM16_FF, ted_pkg::BOM16_FF};
          default: text_q = '{ted_pkg::BOM16_FE};
        endcase
        repeat ($urandom_range(0, 5)) push_char();
        if ($urandom_range(0, 2) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      end else if (flavor < 17) begin
        // valid text with one flaw
        repeat ($urandom_range(0, 4)) push_char();
        flaw = $urandom_range(0, 3);
        case (flaw)
          0: text_q.push_back(ted_pkg::CONT_PAT | 8'($urandom_range(0, 63)));
          1: text_q.push_back(8'($urandom_range(248, 255)));
          2: begin
            text_q.push_back(ted_pkg::LEAD3_PAT | 8'($urandom_range(0, 15)));
            push_conts($urandom_range(0, 1));
            text_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                          : 8'($urandom_range(192, 255)));
          end
          default: begin
            text_q.push_back(ted_pkg::LEAD4_PAT | 8'($urandom_range(0, 7)));
            push_conts($urandom_range(0, 2));
          end
        endcase
        if (flaw != 3) repeat ($urandom_range(0, 3)) push_char();
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text_q[i]) send_beat(text_q[i], (i == text_q.size() - 1), 1'b0, row_v);
    end

    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ted_pkg.sv
rtl/ted_step.sv
rtl/text_encoding_detector.sv
test/text_encoding_detector_tb.sv
